@@ rtl/swt_pkg.sv @@
// Shared types, constants and digit helpers for the stopwatch / countdown timer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

  // Fixed point layout of the kept time
  localparam int FRAC_BITS     = 10;
  localparam int TIME_W        = 29;
  localparam int SEC_W         = TIME_W - FRAC_BITS;
  localparam int ELAPSED_W     = 16;
  localparam int WALL_W        = 17;
  localparam int WIG_LEFT_W    = ELAPSED_W + 2;
  localparam int WIGGLE_PHASES = 3;
  localparam int WIGGLE_W      = (WIGGLE_PHASES > 1) ? $clog2(WIGGLE_PHASES) : 1;

  localparam logic [TIME_W-1:0]    TIME_MAX     = TIME_W'((360000 << FRAC_BITS) - 1);
  localparam logic [ELAPSED_W-1:0] WIGGLE_RESET = ELAPSED_W'(137);

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Reciprocals for the digit split; exact over the seconds range in use
  localparam logic [19:0] HOUR_RECIP = 20'd596524;
  localparam int          HOUR_SHIFT = 31;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;
  localparam int          MIN_SHIFT  = 18;

  // Timer modes
  localparam logic [1:0] MODE_UP    = 2'd0;
  localparam logic [1:0] MODE_DOWN  = 2'd1;
  localparam logic [1:0] MODE_WALL  = 2'd2;

  // Command codes on the input stream
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_TOGGLE  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE         = 3'd0;
  localparam logic [2:0] CFG_START_TIME   = 3'd1;
  localparam logic [2:0] CFG_START_PAUSED = 3'd2;
  localparam logic [2:0] CFG_STOP_AT_ZERO = 3'd3;
  localparam logic [2:0] CFG_WIGGLE       = 3'd4;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_TOGGLE,
    KIND_RESTART,
    KIND_IGNORE
  } kind_t;

  // One classified item as it waits in the queue
  typedef struct packed {
    kind_t                 kind;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [TIME_W-1:0]     wall_time;
  } item_t;

  // Status that travels alongside the time through the digit pipeline
  typedef struct packed {
    logic [WIGGLE_W-1:0] wiggle;
    logic                paused;
    logic                finished;
  } flags_t;

  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    flags_t     flags;
  } result_t;

  function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W:0] v);
    clamp_time = (v > {1'b0, TIME_MAX}) ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  // Tens of a value below 100, counted from independent compares
  function automatic logic [3:0] tens_of(input logic [6:0] x);
    logic [3:0] n;
    n = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 7'(10 * k)) n = n + 4'd1;
    end
    tens_of = n;
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] x, input logic [3:0] tens);
    logic [6:0] tens_x10;
    tens_x10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    units_of = 4'(x - tens_x10);
  endfunction

endpackage

`default_nettype wire

@@ rtl/swt_front.sv @@
// Front part of the timer: takes input transactions and classifies them.
// Turns the command code into a kind and prepares the wall-clock time; uses swt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swt_front
  import swt_pkg::*;
(
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [39:0]           s_tdata,
  input  wire logic [1:0]            s_tuser,
  output logic                       item_valid,
  input  wire logic                  item_ready,
  output item_t                      item
);

  logic [ELAPSED_W-1:0] elapsed;
  logic [WALL_W-1:0]    wall;

  assign elapsed = s_tdata[ELAPSED_W-1:0];
  assign wall    = s_tdata[ELAPSED_W +: WALL_W];

  always_comb begin
    case (s_tuser)
      CMD_TICK:    item.kind = KIND_TICK;
      CMD_TOGGLE:  item.kind = KIND_TOGGLE;
      CMD_RESTART: item.kind = KIND_RESTART;
      default:     item.kind = KIND_IGNORE;
    endcase
    item.elapsed   = elapsed;
    item.wall_time = clamp_time((TIME_W + 1)'(wall) << FRAC_BITS);
  end

  assign item_valid = s_tvalid;
  assign s_tready   = item_ready;

endmodule

`default_nettype wire

@@ rtl/swt_queue.sv @@
// Short queue between the front and back parts of the timer.
// Holds classified items so either side can stall on its own; uses swt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swt_queue
  import swt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              wr_en;
  logic              rd_en;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/swt_back.sv @@
// Back part of the timer: configuration registers, the timer state update and
// the digit pipeline that splits the shown time into HH:MM:SS; uses swt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swt_back
  import swt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res
);

  // Configuration
  logic [1:0]           timer_mode;
  logic [TIME_W-1:0]    start_time;
  logic                 start_paused;
  logic                 stop_at_zero;
  logic [ELAPSED_W-1:0] wiggle_period;

  // Timer state
  logic [TIME_W-1:0]            time_value, time_value_next;
  logic                         paused_flag, paused_flag_next;
  logic [WIGGLE_W-1:0]          phase_count, phase_count_next;
  logic signed [WIG_LEFT_W-1:0] wiggle_left, wiggle_left_next;
  logic                         finished_next;

  logic signed [WIG_LEFT_W-1:0] wiggle_base;
  logic [TIME_W:0]              time_sum;
  logic                         advance;
  logic                         take;

  // Pipeline registers
  logic             s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic [SEC_W-1:0] s1_secs, s2_secs;
  flags_t           s1_flags, s2_flags, s3_flags, s4_flags;
  logic [6:0]       s2_hours;
  logic [3:0]       s3_hour_tens, s3_hour_units, s4_hour_tens, s4_hour_units;
  logic [11:0]      s3_rem, s4_rem;
  logic [5:0]       s4_mins;
  result_t          s5_res;

  logic [38:0]      hour_prod;
  logic [SEC_W-1:0] rem_full;
  logic [24:0]      min_prod;
  logic [11:0]      sec_full;
  logic [6:0]       min_7, sec_7;
  logic [3:0]       min_tens, sec_tens;

  // The whole pipeline moves together whenever the output register can be refilled
  assign advance    = !s5_valid || res_ready;
  assign take       = advance && item_valid;
  assign item_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode    <= MODE_UP;
      start_time    <= '0;
      start_paused  <= 1'b0;
      stop_at_zero  <= 1'b0;
      wiggle_period <= WIGGLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:         timer_mode    <= cfg_data[1:0];
        CFG_START_TIME:   start_time    <= cfg_data[TIME_W-1:0];
        CFG_START_PAUSED: start_paused  <= cfg_data[0];
        CFG_STOP_AT_ZERO: stop_at_zero  <= cfg_data[0];
        CFG_WIGGLE:       wiggle_period <= cfg_data[ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    time_value_next   = time_value;
    paused_flag_next  = paused_flag;
    phase_count_next  = phase_count;
    wiggle_left_next  = wiggle_left;
    finished_next     = 1'b0;
    wiggle_base       = wiggle_left;
    time_sum          = {1'b0, time_value} + (TIME_W + 1)'(item.elapsed);
    case (item.kind)
      KIND_TICK: begin
        if (wiggle_left <= 0) begin
          phase_count_next = (phase_count == WIGGLE_W'(WIGGLE_PHASES - 1)) ?
                             '0 : phase_count + 1'b1;
          wiggle_base      = $signed({2'b00, wiggle_period});
        end
        wiggle_left_next = wiggle_base - $signed({2'b00, item.elapsed});
        if (!paused_flag) begin
          case (timer_mode)
            MODE_UP: time_value_next = clamp_time(time_sum);
            MODE_DOWN: begin
              if (time_value != '0) begin
                time_value_next = (time_value > TIME_W'(item.elapsed)) ?
                                  time_value - TIME_W'(item.elapsed) : '0;
              end else begin
                finished_next = stop_at_zero;
              end
            end
            MODE_WALL: begin
              // Follow the wall clock when it moves ahead, otherwise creep
              // forward within the current second only
              if (item.wall_time > time_value) begin
                time_value_next = item.wall_time;
              end else if (time_sum[TIME_W:FRAC_BITS] ==
                           {1'b0, time_value[TIME_W-1:FRAC_BITS]}) begin
                time_value_next = clamp_time(time_sum);
              end
            end
            default: ;
          endcase
        end
      end
      KIND_TOGGLE:  paused_flag_next = !paused_flag;
      KIND_RESTART: begin
        time_value_next  = clamp_time({1'b0, start_time});
        paused_flag_next = start_paused;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_value  <= '0;
      paused_flag <= 1'b0;
      phase_count <= '0;
      wiggle_left <= $signed({2'b00, WIGGLE_RESET});
    end else if (take) begin
      time_value  <= time_value_next;
      paused_flag <= paused_flag_next;
      phase_count <= phase_count_next;
      wiggle_left <= wiggle_left_next;
    end
  end

  // Digit split: hours by reciprocal, then remainder, minutes by reciprocal,
  // then seconds, with the small tens and units taken beside them.
  assign hour_prod = 39'(s1_secs) * 39'(HOUR_RECIP);
  assign rem_full  = s2_secs - SEC_W'(s2_hours) * SEC_W'(3600);
  assign min_prod  = 25'(s3_rem) * 25'(MIN_RECIP);
  assign sec_full  = s4_rem - 12'(s4_mins) * 12'(60);
  assign min_7     = {1'b0, s4_mins};
  assign sec_7     = {1'b0, sec_full[5:0]};
  assign min_tens  = tens_of(min_7);
  assign sec_tens  = tens_of(sec_7);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_secs           <= time_value[TIME_W-1:FRAC_BITS];
      s1_flags.wiggle   <= phase_count;
      s1_flags.paused   <= paused_flag;
      s1_flags.finished <= finished_next;

      s2_secs  <= s1_secs;
      s2_hours <= hour_prod[HOUR_SHIFT +: 7];
      s2_flags <= s1_flags;

      s3_rem        <= rem_full[11:0];
      s3_hour_tens  <= tens_of(s2_hours);
      s3_hour_units <= units_of(s2_hours, tens_of(s2_hours));
      s3_flags      <= s2_flags;

      s4_rem        <= s3_rem;
      s4_mins       <= min_prod[MIN_SHIFT +: 6];
      s4_hour_tens  <= s3_hour_tens;
      s4_hour_units <= s3_hour_units;
      s4_flags      <= s3_flags;

      s5_res.hour_tens    <= s4_hour_tens;
      s5_res.hour_units   <= s4_hour_units;
      s5_res.minute_tens  <= min_tens[2:0];
      s5_res.minute_units <= units_of(min_7, min_tens);
      s5_res.second_tens  <= sec_tens[2:0];
      s5_res.second_units <= units_of(sec_7, sec_tens);
      s5_res.flags        <= s4_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  assign res_valid = s5_valid;
  assign res       = s5_res;

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    time_value <= TIME_MAX)
    else $error("time value beyond 99:59:59");

  a_finished_at_zero: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_flags.finished |-> s1_secs == '0)
    else $error("finished raised while the shown time is not zero");

  a_hour_remainder: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> s3_rem < 12'd3600)
    else $error("hour split left a remainder of an hour or more");

  a_second_split: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> s4_mins < 6'd60 && sec_full < 12'd60)
    else $error("minute split out of range");

  a_wiggle_bounds: assert property (@(posedge clk) disable iff (rst)
    wiggle_left >= -$signed({2'b00, {ELAPSED_W{1'b1}}}))
    else $error("wiggle cooldown below its lowest reachable value");

endmodule

`default_nettype wire

@@ rtl/stopwatch_countdown_clock_timer_unit.sv @@
// Stopwatch / countdown / wall-clock timer unit: top level.
// Joins swt_front, swt_queue and swt_back; uses swt_pkg.
//
// Input stream (s_*): one transaction per command. s_tuser carries the command
// (tick, toggle pause, restart), s_tdata the tick duration and the time of day.
// Output stream (m_*): exactly one result transaction per accepted command,
// showing HH:MM:SS, the wiggle phase and the pause state as they stood before
// the command, plus the countdown-finished flag.
// Configuration (cfg_*): one register write per transaction, always ready;
// writes are meant for when the block is idle.
// A command leaving the queue passes the registered stages s1 to s5 before its
// result is offered. One command is taken every cycle unless the receiver stalls;
// the state update feeds back only into its own registers, and the digit split is
// a five-stage pipeline with its two reciprocal multipliers in separate stages.
// When the receiver stalls the pipeline holds and the input queue fills, after
// which s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties queue and pipeline and returns the time,
// pause state, wiggle state and configuration to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_countdown_clock_timer_unit
  import swt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // elapsed[15:0], wall_seconds[32:16], zero fill above
  input  wire logic [39:0] s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // hour_tens[3:0], hour_units[7:4], minute_tens[10:8], minute_units[14:11],
  // second_tens[17:15], second_units[21:18], wiggle_phase[23:22],
  // is_paused[24], finished[25], zero fill above
  output logic [31:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [28:0] cfg_data
);

  logic    front_valid, front_ready;
  item_t   front_item;
  logic    q_valid, q_ready;
  item_t   q_item;
  result_t res;

  swt_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  swt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  swt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign cfg_ready = 1'b1;

  assign m_tdata = {6'b000000,
                    res.flags.finished,
                    res.flags.paused,
                    res.flags.wiggle,
                    res.second_units,
                    res.second_tens,
                    res.minute_units,
                    res.minute_tens,
                    res.hour_units,
                    res.hour_tens};

endmodule

`default_nettype wire

@@ verif/timer_check.sv @@
// Checker for the stopwatch / countdown / wall-clock timer unit: tracks its own copy
// of the timer state and settings and compares every result transaction in order.
// Depends on swt_pkg for widths, mode, command and register index codes.
`timescale 1ns / 1ps

module timer_check
  import swt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  // What one result transaction shows
  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic [1:0] phase;
    logic       paused;
    logic       finished;
  } shown_t;

  shown_t shown_q[$];
  shown_t want;

  // Settings
  logic [1:0]           mode;
  logic [TIME_W-1:0]    start_time;
  logic                 start_paused;
  logic                 stop_at_zero;
  logic [ELAPSED_W-1:0] wig_period;

  // Timer state
  logic [TIME_W-1:0]           time_val;
  logic                        paused;
  logic [1:0]                  wig_count;
  logic signed [WIG_LEFT_W-1:0] wig_left;

  function automatic logic [TIME_W-1:0] sat_time(input logic [63:0] v);
    sat_time = (v > 64'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
  endfunction

  function automatic int field_diff(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  task automatic write_setting(input logic [2:0] idx, input logic [28:0] val);
    case (idx)
      CFG_MODE:         mode = val[1:0];
      CFG_START_TIME:   start_time = val;
      CFG_START_PAUSED: start_paused = val[0];
      CFG_STOP_AT_ZERO: stop_at_zero = val[0];
      CFG_WIGGLE:       wig_period = val[ELAPSED_W-1:0];
      default: ;
    endcase
  endtask

  // Works out what one command shows, then applies it to the timer state.
  task automatic step_timer(input logic [1:0] cmd, input logic [ELAPSED_W-1:0] dt,
                            input logic [WALL_W-1:0] wall, output shown_t res);
    int secs, hrs, mins, sc;
    logic [63:0] prev, cand, sum;
    secs = int'(time_val >> FRAC_BITS);
    hrs  = secs / 3600;
    mins = (secs / 60) % 60;
    sc   = secs % 60;
    res.hour_tens    = 4'(hrs / 10);
    res.hour_units   = 4'(hrs % 10);
    res.minute_tens  = 3'(mins / 10);
    res.minute_units = 4'(mins % 10);
    res.second_tens  = 3'(sc / 10);
    res.second_units = 4'(sc % 10);
    res.phase        = wig_count;
    res.paused       = paused;
    res.finished     = 1'b0;
    case (cmd)
      CMD_TICK: begin
        // The wiggle cooldown runs even while paused.
        if (wig_left <= 0) begin
          wig_count = 2'((wig_count + 1) % WIGGLE_PHASES);
          wig_left  = $signed({2'b00, wig_period});
        end
        wig_left = wig_left - $signed({2'b00, dt});
        if (!paused) begin
          case (mode)
            MODE_UP: time_val = sat_time(64'(time_val) + 64'(dt));
            MODE_DOWN: begin
              if (time_val != '0) begin
                time_val = (time_val > TIME_W'(dt)) ? time_val - TIME_W'(dt) : '0;
              end else begin
                res.finished = stop_at_zero;
              end
            end
            MODE_WALL: begin
              // Follow the wall clock when it is ahead; otherwise interpolate
              // within the current second but never across into the next one.
              prev = 64'(time_val);
              cand = 64'(sat_time(64'(wall) << FRAC_BITS));
              if (cand <= prev) begin
                sum = prev + 64'(dt);
                if ((prev >> FRAC_BITS) == (sum >> FRAC_BITS)) cand = 64'(sat_time(sum));
                else cand = prev;
              end
              time_val = cand[TIME_W-1:0];
            end
            default: ;
          endcase
        end
      end
      CMD_TOGGLE: paused = ~paused;
      CMD_RESTART: begin
        time_val = sat_time(64'(start_time));
        paused   = start_paused;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode         = MODE_UP;
      start_time   = '0;
      start_paused = 1'b0;
      stop_at_zero = 1'b0;
      wig_period   = WIGGLE_RESET;
      time_val     = '0;
      paused       = 1'b0;
      wig_count    = '0;
      wig_left     = $signed({2'b00, WIGGLE_RESET});
      shown_q.delete();
      mismatches   = 0;
      pending      = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        step_timer(s_tuser, s_tdata[15:0], s_tdata[32:16], want);
        shown_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (shown_q.size() == 0) begin
          $display("%0t ns: result transaction with nothing expected, expected none, got %h",
                   $time, m_tdata);
          mismatches++;
        end else begin
          want = shown_q.pop_front();
          mismatches += field_diff("hour_tens", want.hour_tens, m_tdata[3:0]);
          mismatches += field_diff("hour_units", want.hour_units, m_tdata[7:4]);
          mismatches += field_diff("minute_tens", want.minute_tens, m_tdata[10:8]);
          mismatches += field_diff("minute_units", want.minute_units, m_tdata[14:11]);
          mismatches += field_diff("second_tens", want.second_tens, m_tdata[17:15]);
          mismatches += field_diff("second_units", want.second_units, m_tdata[21:18]);
          mismatches += field_diff("wiggle_phase", want.phase, m_tdata[23:22]);
          mismatches += field_diff("is_paused", want.paused, m_tdata[24]);
          mismatches += field_diff("finished", want.finished, m_tdata[25]);
          mismatches += field_diff("zero fill", 0, m_tdata[31:26]);
        end
      end
      pending = shown_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the timer unit testbench: clock, reset, command and configuration stimulus,
// a randomly stalling receiver, a watchdog and the verdict.
// Depends on swt_pkg, stopwatch_countdown_clock_timer_unit and timer_check.
`timescale 1ns / 1ps

module testbench;
  import swt_pkg::*;

  localparam logic [1:0]  CMD_SPARE    = 2'd3;
  localparam logic [1:0]  MODE_SPARE   = 2'd3;
  localparam logic [2:0]  CFG_SPARE_LO = 3'd5;
  localparam logic [2:0]  CFG_SPARE_HI = 3'd7;
  localparam logic [28:0] START_FULL   = 29'h1FFFFFFF;
  localparam int          WALL_TOP     = 131071;
  localparam int          DAY_LAST     = 86399;
  localparam int          FIN_BIT      = 25;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          PHASES       = 20;
  localparam int          PHASE_ITEMS  = 81;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [28:0] cfg_data;

  int mismatches, pending;
  int items_sent, results_seen, finishes_seen, idle_cycles, phases_run;
  bit steady;
  int wall_now;

  stopwatch_countdown_clock_timer_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  timer_check checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: a run that stops moving transactions is a failure.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_seen  <= 0;
      finishes_seen <= 0;
    end else if (m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (m_tdata[FIN_BIT]) finishes_seen <= finishes_seen + 1;
    end
  end

  // Receiver: holds off a random number of cycles before taking each result.
  initial begin
    int n;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 15);
      repeat (n) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] el,
                           input logic [16:0] wl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, wl, el};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [28:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, 2047));
      6, 7:    return 16'($urandom_range(0, 16383));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [28:0] pick_start();
    case ($urandom_range(0, 7))
      0:       return 29'd0;
      1:       return TIME_MAX;
      2:       return START_FULL;
      3, 4, 5: return 29'($urandom_range(0, 200000));
      default: return 29'($urandom);
    endcase
  endfunction

  task automatic configure_phase();
    int r;
    logic [1:0] md;
    logic [15:0] wig;
    r  = $urandom_range(0, 7);
    md = (r == 7) ? MODE_SPARE : 2'(r % 3);
    if ($urandom_range(0, 3) != 0) write_reg(CFG_MODE, {27'($urandom), md});
    if ($urandom_range(0, 3) != 0) write_reg(CFG_START_TIME, pick_start());
    if ($urandom_range(0, 3) != 0) write_reg(CFG_START_PAUSED, {28'($urandom), 1'($urandom)});
    if ($urandom_range(0, 3) != 0)
      write_reg(CFG_STOP_AT_ZERO, {28'($urandom), 1'($urandom_range(0, 3) != 0)});
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 5))
        0:       wig = 16'd0;
        1:       wig = 16'd1;
        2:       wig = 16'hFFFF;
        default: wig = 16'($urandom_range(1, 4000));
      endcase
      write_reg(CFG_WIGGLE, {13'($urandom), wig});
    end
    if ($urandom_range(0, 5) == 0)
      write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 29'($urandom));
    end_writes();
  endtask

  initial begin
    int pick;
    logic [1:0] cmd;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_TICK;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    steady = 1'b0;
    items_sent = 0;
    phases_run = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings as after reset: ascending, extremes of the fields, pause and spare command.
    send_item(CMD_TICK, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'hFFFF, 17'(WALL_TOP));
    send_item(CMD_TOGGLE, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'd1000, 17'd0);
    send_item(CMD_TOGGLE, 16'd0, 17'd0);
    send_item(CMD_SPARE, 16'hFFFF, 17'(WALL_TOP));
    send_item(CMD_RESTART, 16'd0, 17'd0);

    // Ascending into saturation at 99:59:59.
    drain();
    write_reg(CFG_START_TIME, TIME_MAX - 29'd100);
    end_writes();
    send_item(CMD_RESTART, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'hFFFF, 17'd0);
    send_item(CMD_TICK, 16'hFFFF, 17'd0);

    // Countdown to zero with the finished flag, starting paused, wiggle every tick.
    drain();
    write_reg(CFG_MODE, {27'd0, MODE_DOWN});
    write_reg(CFG_START_TIME, 29'd3000);
    write_reg(CFG_START_PAUSED, 29'd1);
    write_reg(CFG_STOP_AT_ZERO, 29'd1);
    write_reg(CFG_WIGGLE, 29'd0);
    end_writes();
    send_item(CMD_RESTART, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'd500, 17'd0);
    send_item(CMD_TOGGLE, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'd2000, 17'd0);
    send_item(CMD_TICK, 16'd2000, 17'd0);
    send_item(CMD_TICK, 16'd5, 17'd0);
    send_item(CMD_TICK, 16'd0, 17'd0);

    // Wall clock: oversized start, holding at a second boundary, following the wall.
    drain();
    write_reg(CFG_MODE, {27'd0, MODE_WALL});
    write_reg(CFG_START_TIME, START_FULL);
    write_reg(CFG_START_PAUSED, 29'd0);
    write_reg(CFG_STOP_AT_ZERO, 29'd0);
    write_reg(CFG_WIGGLE, 29'hFFFF);
    write_reg(CFG_SPARE_HI, START_FULL);
    end_writes();
    send_item(CMD_RESTART, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'd5, 17'(DAY_LAST));
    drain();
    write_reg(CFG_START_TIME, 29'd0);
    end_writes();
    send_item(CMD_RESTART, 16'd0, 17'd0);
    send_item(CMD_TICK, 16'd0, 17'd100);
    send_item(CMD_TICK, 16'd500, 17'd100);
    send_item(CMD_TICK, 16'd600, 17'd100);
    send_item(CMD_TICK, 16'd7, 17'(WALL_TOP));

    // An unknown mode leaves the time alone.
    drain();
    write_reg(CFG_MODE, {27'd0, MODE_SPARE});
    end_writes();
    send_item(CMD_TICK, 16'hFFFF, 17'd0);
    send_item(CMD_TICK, 16'd1, 17'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      configure_phase();
      phases_run++;
      wall_now = $urandom_range(0, DAY_LAST);
      if ($urandom_range(0, 3) != 0) send_item(CMD_RESTART, pick_elapsed(), 17'(wall_now));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) cmd = CMD_TICK;
        else if (pick < 84) cmd = CMD_TOGGLE;
        else if (pick < 94) cmd = CMD_RESTART;
        else cmd = CMD_SPARE;
        pick = $urandom_range(0, 19);
        if (pick == 0) wall_now = $urandom_range(0, WALL_TOP);
        else if (pick < 8 && wall_now < WALL_TOP) wall_now++;
        send_item(cmd, pick_elapsed(), 17'(wall_now));
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d commands over %0d random setting phases plus a directed opening.",
             items_sent, phases_run);
    $display("Checked %0d results, %0d of them with the countdown finished flag raised.",
             results_seen, finishes_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
